/* rtl/pmt_pkg.sv */
// ----------------------------------------------------------------------------
// Point matrix transform package
// Shared payload types, register map codes and divider sizes.
// ----------------------------------------------------------------------------
package pmt_pkg;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_zero;
    logic               saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    RegMode    = 3'd0,
    RegColumnX = 3'd1,
    RegColumnY = 3'd2,
    RegColumnZ = 3'd3,
    RegColumnW = 3'd4
  } reg_addr_e;

  localparam int unsigned SumW     = 51;
  localparam int unsigned MagW     = 50;
  localparam int unsigned QuotBits = 33;
  localparam int unsigned DivSteps = 11;
  localparam int unsigned BitsPerStep = 3;

  localparam logic [63:0] ResetColX = 64'h0000_0000_0000_0100;
  localparam logic [63:0] ResetColY = 64'h0000_0000_0100_0000;
  localparam logic [63:0] ResetColZ = 64'h0000_0100_0000_0000;
  localparam logic [63:0] ResetColW = 64'h0100_0000_0000_0000;

  typedef struct packed {
    logic            point;
    logic            w_zero;
    logic [2:0]      neg;
    logic [2:0][MagW-1:0] rem;
    logic [2:0][QuotBits-1:0] quot;
    logic [2:0][SumW-1:0] sum;
    logic [MagW-1:0] den;
    logic [2:0]      big;
  } div_state_t;

endpackage

/* rtl/point_matrix_transform_unit.sv */
// ----------------------------------------------------------------------------
// Point matrix transform unit
// Multiplies a Q16.16 vector by a Q8.8 4x4 matrix, with perspective divide in point mode.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  input     start_i while !busy_o   in_item_i (in_x, in_y, in_z)
//  result    done_o one cycle        out_item_o (xyz, w_zero, saturated)
//  config    APB write, 64-bit data  mode, column_x/y/z/w
//
// A vector may be started every cycle; busy_o stays low.
// Its result passes through two multiply and sum stages, one sign stage,
// eleven divider stages and a saturation stage.
// Reset clears the valid bits and restores the identity matrix in point mode.
// The receiver cannot stall, so the pipeline never holds.
module point_matrix_transform_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  pmt_pkg::in_item_t  in_item_i,
  output logic               done_o,
  output pmt_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int unsigned SW = pmt_pkg::SumW;
  localparam int unsigned MW = pmt_pkg::MagW;
  localparam int unsigned QW = pmt_pkg::QuotBits;

  logic        mode_q;
  logic [63:0] col_q [4];
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign busy_o  = 1'b0;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      col_q[0] <= pmt_pkg::ResetColX;
      col_q[1] <= pmt_pkg::ResetColY;
      col_q[2] <= pmt_pkg::ResetColZ;
      col_q[3] <= pmt_pkg::ResetColW;
    end else if (wr_en) begin
      unique case (reg_idx)
        pmt_pkg::RegMode:    mode_q   <= pwdata[0];
        pmt_pkg::RegColumnX: col_q[0] <= pwdata;
        pmt_pkg::RegColumnY: col_q[1] <= pwdata;
        pmt_pkg::RegColumnZ: col_q[2] <= pwdata;
        pmt_pkg::RegColumnW: col_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pmt_pkg::RegMode:    prdata = {63'd0, mode_q};
      pmt_pkg::RegColumnX: prdata = col_q[0];
      pmt_pkg::RegColumnY: prdata = col_q[1];
      pmt_pkg::RegColumnZ: prdata = col_q[2];
      pmt_pkg::RegColumnW: prdata = col_q[3];
      default:             prdata = 64'd0;
    endcase
  end

  // Stage 1: the twelve products.
  logic                 v1_q;
  logic                 pt1_q;
  logic signed [47:0]   prod_q [4][3];
  logic signed [15:0]   trans_q [4];
  logic                 accept;

  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i) begin
    pt1_q <= !mode_q;
    for (int c = 0; c < 4; c++) begin
      prod_q[c][0] <= in_item_i.in_x * $signed(col_q[c][15:0]);
      prod_q[c][1] <= in_item_i.in_y * $signed(col_q[c][31:16]);
      prod_q[c][2] <= in_item_i.in_z * $signed(col_q[c][47:32]);
      trans_q[c]   <= $signed(col_q[c][63:48]);
    end
  end

  // Stage 2: column sums.
  logic                 v2_q;
  logic                 pt2_q;
  logic signed [SW-1:0] sum_q [4];

  always_ff @(posedge clk_i) begin
    pt2_q <= pt1_q;
    for (int c = 0; c < 4; c++) begin
      sum_q[c] <= SW'(prod_q[c][0]) + SW'(prod_q[c][1]) + SW'(prod_q[c][2])
                + (pt1_q ? {{(SW-32){trans_q[c][15]}}, trans_q[c], 16'd0} : SW'(0));
    end
  end

  // Stage 3: magnitudes and signs for the divider.
  logic                v3_q;
  pmt_pkg::div_state_t ds3_d;
  pmt_pkg::div_state_t ds3_q;

  // The upper dividend bits seed the remainder; the remaining low magnitude
  // bits followed by sixteen zero bits are fed in one per quotient bit.
  always_comb begin
    logic          sw_neg;
    logic [MW-1:0] wm;
    logic [SW-1:0] nm;
    sw_neg       = sum_q[3][SW-1];
    wm           = sw_neg ? MW'(-sum_q[3]) : MW'(sum_q[3]);
    nm           = '0;
    ds3_d        = '0;
    ds3_d.point  = pt2_q;
    ds3_d.w_zero = pt2_q && (sum_q[3] == '0);
    ds3_d.den    = wm;
    for (int c = 0; c < 3; c++) begin
      nm = sum_q[c][SW-1] ? SW'(-sum_q[c]) : SW'(sum_q[c]);
      ds3_d.neg[c] = sum_q[c][SW-1] ^ sw_neg;
      if (pt2_q) begin
        ds3_d.rem[c] = MW'(nm[SW-1:SW-QW-1]);
        ds3_d.big[c] = MW'(nm[SW-1:SW-QW-1]) >= wm;
        ds3_d.sum[c] = {1'b0, nm[SW-QW-2:0], {QW{1'b0}}};
      end else begin
        ds3_d.sum[c] = sum_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ds3_q <= ds3_d;
  end

  logic                v_div  [pmt_pkg::DivSteps+1];
  pmt_pkg::div_state_t ds_div [pmt_pkg::DivSteps+1];
  logic                v_out;
  pmt_pkg::div_state_t ds6;

  assign v_div[0]  = v3_q;
  assign ds_div[0] = ds3_q;

  for (genvar g = 0; g < pmt_pkg::DivSteps; g++) begin : g_div
    pmt_div_stage u_div (.clk_i, .rst_ni, .valid_i(v_div[g]), .state_i(ds_div[g]),
                         .valid_o(v_div[g+1]), .state_o(ds_div[g+1]));
  end

  assign v_out = v_div[pmt_pkg::DivSteps];
  assign ds6   = ds_div[pmt_pkg::DivSteps];

  // Final stage: sign, saturation and result register.
  logic               v7_q;
  pmt_pkg::out_item_t res_q;

  always_ff @(posedge clk_i) begin
    logic [31:0] r [3];
    logic        sat;
    sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      logic [SW-1:0] fl;
      if (ds6.point) begin
        if (ds6.w_zero) begin
          r[c] = 32'd0;
        end else if (ds6.big[c] || (ds6.quot[c] > {1'b0, ds6.neg[c], {31{!ds6.neg[c]}}})) begin
          sat  = 1'b1;
          r[c] = ds6.neg[c] ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
          r[c] = ds6.neg[c] ? 32'(-ds6.quot[c]) : ds6.quot[c][31:0];
        end
      end else begin
        fl = $signed(ds6.sum[c]) >>> 8;
        if ($signed(fl) > $signed(SW'(32'sh7fff_ffff))) begin
          sat = 1'b1; r[c] = 32'h7fff_ffff;
        end else if ($signed(fl) < -$signed(SW'(64'sh8000_0000))) begin
          sat = 1'b1; r[c] = 32'h8000_0000;
        end else begin
          r[c] = fl[31:0];
        end
      end
    end
    res_q.out_x     <= r[0];
    res_q.out_y     <= r[1];
    res_q.out_z     <= r[2];
    res_q.w_zero    <= ds6.point && ds6.w_zero;
    res_q.saturated <= sat && !(ds6.point && ds6.w_zero);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v7_q <= v_out;
    end
  end

  assign done_o     = v7_q;
  assign out_item_o = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) v_div[0] |=> v_div[1])
    else $error("divider lost an item");
  assert property (@(posedge clk_i) disable iff (!rst_ni) v_out |=> done_o)
    else $error("result stage lost an item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_item_o.w_zero |-> !out_item_o.saturated)
    else $error("w zero result flagged as saturated");

endmodule

/* rtl/pmt_div_stage.sv */
// ----------------------------------------------------------------------------
// Point matrix transform divider stage
// Takes three restoring quotient bits for all three components per stage in point mode.
// ----------------------------------------------------------------------------
module pmt_div_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  pmt_pkg::div_state_t state_i,
  output logic                valid_o,
  output pmt_pkg::div_state_t state_o
);

  logic                valid_q;
  pmt_pkg::div_state_t state_q;
  pmt_pkg::div_state_t state_d;

  always_comb begin
    logic [pmt_pkg::MagW:0] r;
    r       = '0;
    state_d = state_i;
    if (state_i.point) begin
      for (int c = 0; c < 3; c++) begin
        for (int b = 0; b < pmt_pkg::BitsPerStep; b++) begin
          r = {state_d.rem[c], state_d.sum[c][pmt_pkg::SumW-2]};
          state_d.sum[c] = {state_d.sum[c][pmt_pkg::SumW-2:0], 1'b0};
          if (r >= {1'b0, state_d.den}) begin
            r = r - {1'b0, state_d.den};
            state_d.quot[c] = {state_d.quot[c][pmt_pkg::QuotBits-2:0], 1'b1};
          end else begin
            state_d.quot[c] = {state_d.quot[c][pmt_pkg::QuotBits-2:0], 1'b0};
          end
          if (state_d.quot[c][pmt_pkg::QuotBits-1]) begin
            state_d.big[c] = 1'b1;
          end
          state_d.rem[c] = r[pmt_pkg::MagW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Point matrix transform unit testbench
// Drives vectors through the unit under several matrix and mode settings,
// predicts every result with an independent fixed-point model and compares
// the results field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned Latency  = 15;
  localparam int unsigned MaxCycles = 400000;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  pmt_pkg::in_item_t  in_item_i;
  logic               done_o;
  pmt_pkg::out_item_t out_item_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [5:0]         paddr;
  logic [63:0]        pwdata;
  logic [63:0]        prdata;
  logic               pready;

  logic        cfg_mode;
  logic [63:0] cfg_col [4];

  pmt_pkg::out_item_t expected_q [$];
  int unsigned fail_count;
  int unsigned result_count;
  int unsigned w_zero_count;
  int unsigned sat_count;
  int unsigned cycle_count;
  int unsigned idle_pct;

  typedef struct {
    pmt_pkg::in_item_t  vec;
    bit                 has_exp;
    pmt_pkg::out_item_t exp;
  } vec_row_t;

  point_matrix_transform_unit DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic signed [63:0] coef(logic [63:0] column, int row);
    return 64'(signed'(column[16*row +: 16]));
  endfunction

  function automatic logic signed [63:0] col_sum(logic [63:0] column, logic signed [63:0] x,
                                                 logic signed [63:0] y, logic signed [63:0] z,
                                                 bit point);
    logic signed [63:0] s;
    s = x * coef(column, 0) + y * coef(column, 1) + z * coef(column, 2);
    if (point) s += coef(column, 3) * 64'sd65536;
    return s;
  endfunction

  function automatic logic [31:0] persp_div(logic signed [63:0] num, logic signed [63:0] den,
                                            ref bit sat);
    bit          neg;
    logic [63:0] un;
    logic [63:0] ud;
    logic [63:0] q;
    logic [63:0] lim;
    neg = (num < 0) != (den < 0);
    un  = num < 0 ? -num : num;
    ud  = den < 0 ? -den : den;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (un / ud >= 65536) q = lim;
    else q = ((un / ud) << 16) | (((un % ud) << 16) / ud);
    if (q > lim) begin
      q = lim;
      sat = 1;
    end
    if (un / ud >= 65536) sat = 1;
    return neg ? 32'(-q) : 32'(q);
  endfunction

  function automatic logic [31:0] clip_floor(logic signed [63:0] v, ref bit sat);
    logic signed [63:0] f;
    f = v >>> 8;
    if (f > 64'sd2147483647) begin
      sat = 1;
      return 32'h7FFF_FFFF;
    end
    if (f < -64'sd2147483648) begin
      sat = 1;
      return 32'h8000_0000;
    end
    return f[31:0];
  endfunction

  function automatic pmt_pkg::out_item_t transform(pmt_pkg::in_item_t v);
    pmt_pkg::out_item_t r;
    logic signed [63:0] s [4];
    bit                 sat;
    bit                 point;
    point = !cfg_mode;
    sat = 0;
    r = '0;
    for (int c = 0; c < 4; c++)
      s[c] = col_sum(cfg_col[c], 64'(v.in_x), 64'(v.in_y), 64'(v.in_z), point);
    if (point) begin
      if (s[3] == 0) begin
        r.w_zero = 1'b1;
      end else begin
        r.out_x = persp_div(s[0], s[3], sat);
        r.out_y = persp_div(s[1], s[3], sat);
        r.out_z = persp_div(s[2], s[3], sat);
      end
    end else begin
      r.out_x = clip_floor(s[0], sat);
      r.out_y = clip_floor(s[1], sat);
      r.out_z = clip_floor(s[2], sat);
    end
    r.saturated = sat;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item_o);
        fail_count <= fail_count + 1;
      end else begin
        pmt_pkg::out_item_t e;
        e = expected_q.pop_front();
        result_count <= result_count + 1;
        if (e.w_zero) w_zero_count <= w_zero_count + 1;
        if (e.saturated) sat_count <= sat_count + 1;
        if (out_item_o.out_x !== e.out_x || out_item_o.out_y !== e.out_y ||
            out_item_o.out_z !== e.out_z || out_item_o.w_zero !== e.w_zero ||
            out_item_o.saturated !== e.saturated) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h wz=%b sat=%b", $time, e.out_x,
                   e.out_y, e.out_z, e.w_zero, e.saturated);
          $display("%0t:          actual   x=%h y=%h z=%h wz=%b sat=%b", $time,
                   out_item_o.out_x, out_item_o.out_y, out_item_o.out_z,
                   out_item_o.w_zero, out_item_o.saturated);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  task automatic write_reg(pmt_pkg::reg_addr_e idx, logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(idx) << 3;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == pmt_pkg::RegMode) cfg_mode = value[0];
    else cfg_col[int'(idx) - 1] = value;
  endtask

  task automatic drain_pipe();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic load_matrix(logic mode, logic [63:0] cx, logic [63:0] cy, logic [63:0] cz,
                             logic [63:0] cw);
    drain_pipe();
    write_reg(pmt_pkg::RegMode, {63'(1) << 2, mode});
    write_reg(pmt_pkg::RegColumnX, cx);
    write_reg(pmt_pkg::RegColumnY, cy);
    write_reg(pmt_pkg::RegColumnZ, cz);
    write_reg(pmt_pkg::RegColumnW, cw);
  endtask

  // Holds start high across back-to-back transfers and only lowers it on a gap.
  task automatic send_vector(pmt_pkg::in_item_t v, bit has_exp = 0,
                             pmt_pkg::out_item_t exp = '0);
    pmt_pkg::out_item_t p;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    p = transform(v);
    if (has_exp && p !== exp) begin
      $display("%0t: table entry disagrees, expected %h predicted %h", $time, exp, p);
      fail_count++;
    end
    start_i   <= 1'b1;
    in_item_i <= v;
    do @(posedge clk_i); while (busy_o);
    expected_q.push_back(p);
  endtask

  function automatic logic [63:0] rand_column(int kind);
    logic [63:0] c;
    c = {$urandom, $urandom};
    for (int r = 0; r < 4; r++)
      if (kind == 0) c[16*r +: 16] = 16'($signed($urandom_range(1024)) - 512);
    return c;
  endfunction

  function automatic pmt_pkg::in_item_t rand_vector(int kind);
    pmt_pkg::in_item_t v;
    v = {$urandom, $urandom, $urandom};
    if (kind < 3) begin
      v.in_x = $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
      v.in_y = $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
      v.in_z = $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
    end
    return v;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0) begin
        start_i <= 1'b0;
        drain_pipe();
        load_matrix(1'($urandom_range(1)), rand_column($urandom_range(2)),
                    rand_column($urandom_range(2)), rand_column($urandom_range(2)),
                    $urandom_range(5) == 0 ? 64'h0 : rand_column($urandom_range(2)));
      end
      send_vector(rand_vector($urandom_range(4)));
    end
    start_i <= 1'b0;
  endtask

  initial begin
    vec_row_t rows [$];
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_item_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycle_count = 0;
    fail_count = 0;
    idle_pct = 0;
    cfg_mode = 1'b0;
    cfg_col[0] = pmt_pkg::ResetColX;
    cfg_col[1] = pmt_pkg::ResetColY;
    cfg_col[2] = pmt_pkg::ResetColZ;
    cfg_col[3] = pmt_pkg::ResetColW;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    rows.push_back('{'{32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000}, 1,
                     '{32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 1'b0, 1'b0}});
    rows.push_back('{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0}, 1,
                     '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, 1'b0}});
    rows.push_back('{'{32'hFFFF_FFFF, 32'h0, 32'h1}, 1,
                     '{32'hFFFF_FFFF, 32'h0, 32'h1, 1'b0, 1'b0}});
    foreach (rows[i]) send_vector(rows[i].vec, rows[i].has_exp, rows[i].exp);
    start_i <= 1'b0;

    // w taken from z: a zero z gives w zero, tiny w overflows the divide
    load_matrix(1'b0, pmt_pkg::ResetColX, pmt_pkg::ResetColY, pmt_pkg::ResetColZ,
                64'h0000_0100_0000_0000);
    send_vector('{32'h0001_0000, 32'h0001_0000, 32'h0}, 1, '{0, 0, 0, 1'b1, 1'b0});
    send_vector('{32'h7FFF_FFFF, 32'h8000_0000, 32'h1}, 1,
                '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0, 1'b1});
    send_vector('{32'h0003_0000, 32'hFFFD_0000, 32'hFFFE_0000});
    send_vector('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    start_i <= 1'b0;

    load_matrix(1'b1, 64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF,
                64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_vector('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_vector('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_vector('{32'hFFFF_FFFF, 32'h0, 32'h0});
    send_vector('{32'h0, 32'h0, 32'h0}, 1, '{0, 0, 0, 1'b0, 1'b0});
    start_i <= 1'b0;

    load_matrix(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_8000_8000_8000,
                64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_0000_0000_0000);
    send_vector('{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678});
    send_vector('{32'h0, 32'h0, 32'h0});
    start_i <= 1'b0;

    idle_pct = 18;
    random_phase(320);
    idle_pct = 51;
    random_phase(320);
    idle_pct = 0;
    random_phase(300);

    drain_pipe();
    $display("Checked %0d results over point and normal modes and random matrices.",
             result_count);
    $display("%0d results had w equal to zero and %0d were clipped.", w_zero_count,
             sat_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
